>>> rtl/qfts_pkg.sv
// ============================================================================
// qfts_pkg
// Shared types and codes for the two-stack queue: operation and status codes
// and the command and status groups between controller and datapath.
// ============================================================================
package qfts_pkg;

    // Width of the word carried on the result and request ports
    localparam int PORT_WORD_BITS = 32;

    // Operation codes carried with each request
    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_FRONT = 2'd2,
        OP_EMPTY = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    push_in;    // write request word onto the input stack
        logic    xfer_rd;    // read input-stack top and pop it
        logic    xfer_wr;    // push the word just read onto the output stack
        logic    top_rd;     // read output-stack top
        logic    load_out;   // load the result register
        logic    from_ram;   // result word comes from the output-stack read
        logic    pop;        // pop the output stack with this result
        status_t st;         // status of this result
    } qfts_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_empty;
        logic in_full;
        logic out_empty;
    } qfts_stat_t;

endpackage

>>> rtl/qfts_ram.sv
// ============================================================================
// qfts_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// Read data holds until the next read.
// ============================================================================
module qfts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/qfts_dp.sv
// ============================================================================
// qfts_dp
// Datapath of the two-stack queue: the two stack memories, their fill
// counters and the result register.
// ============================================================================
module qfts_dp #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  qfts_pkg::qfts_cmd_t                   cmd,
    input  logic [qfts_pkg::PORT_WORD_BITS-1:0]   value,
    output qfts_pkg::qfts_stat_t                  stat,
    output logic [qfts_pkg::PORT_WORD_BITS-1:0]   result_value,
    output qfts_pkg::status_t                     status,
    output logic                                  is_empty
);

    import qfts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0] in_count_reg, in_count_next;
    logic [CW-1:0] out_count_reg, out_count_next;
    logic [CW-1:0] in_dec, out_dec;

    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] in_rdata;
    logic [WORD_BITS-1:0] out_rdata;
    logic [PORT_WORD_BITS-1:0] ram_result;

    logic [PORT_WORD_BITS-1:0] result_value_reg;
    status_t                   status_reg;
    logic                      is_empty_reg;

    // Fit the request word to the stored width and back
    if (WORD_BITS >= PORT_WORD_BITS)
    begin : g_wide
        assign word       = WORD_BITS'(value);
        assign ram_result = out_rdata[PORT_WORD_BITS-1:0];
    end
    else
    begin : g_narrow
        assign word       = value[WORD_BITS-1:0];
        assign ram_result = {{(PORT_WORD_BITS - WORD_BITS){1'b0}}, out_rdata};
    end

    assign in_dec  = in_count_reg - CW'(1);
    assign out_dec = out_count_reg - CW'(1);

    // Input stack
    qfts_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_in_ram (
        .clk     (clk),
        .wr_en   (cmd.push_in),
        .wr_addr (in_count_reg[AW-1:0]),
        .wr_data (word),
        .rd_en   (cmd.xfer_rd),
        .rd_addr (in_dec[AW-1:0]),
        .rd_data (in_rdata)
    );

    // Output stack
    qfts_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_out_ram (
        .clk     (clk),
        .wr_en   (cmd.xfer_wr),
        .wr_addr (out_count_reg[AW-1:0]),
        .wr_data (in_rdata),
        .rd_en   (cmd.top_rd),
        .rd_addr (out_dec[AW-1:0]),
        .rd_data (out_rdata)
    );

    // Advance fill counters
    always_comb
    begin
        in_count_next  = in_count_reg + CW'(cmd.push_in) - CW'(cmd.xfer_rd);
        out_count_next = out_count_reg + CW'(cmd.xfer_wr) - CW'(cmd.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
        end
    end

    // Load result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_value_reg <= cmd.from_ram ? ram_result : '0;
            status_reg       <= cmd.st;
            is_empty_reg     <= (in_count_next == '0) && (out_count_next == '0);
        end
    end

    assign stat.in_empty  = (in_count_reg == '0);
    assign stat.in_full   = (in_count_reg == FULL_COUNT);
    assign stat.out_empty = (out_count_reg == '0);

    assign result_value = result_value_reg;
    assign status       = status_reg;
    assign is_empty     = is_empty_reg;

    // Checks
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_in |-> !stat.in_full)
        else $error("push onto full input stack");

    a_xfer_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.xfer_wr |-> (out_count_reg < FULL_COUNT))
        else $error("transfer onto full output stack");

    a_top_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.top_rd |-> !stat.out_empty)
        else $error("read of empty output stack");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (in_count_reg + out_count_reg) <= (CW + 1)'(2 * DEPTH))
        else $error("stack counters out of range");

endmodule

>>> rtl/qfts_ctrl.sv
// ============================================================================
// qfts_ctrl
// Controller of the two-stack queue: decodes each request, sequences the
// refill of the output stack and owns the result valid flag.
// ============================================================================
module qfts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           func,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  qfts_pkg::qfts_stat_t stat,
    output qfts_pkg::qfts_cmd_t  cmd
);

    import qfts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_XFER_RD,
        S_XFER_WR,
        S_TOP_RD,
        S_RD_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   pop_reg, pop_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;
    func_t  op;

    assign op       = func_t'(func);
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Decode and sequence
    always_comb
    begin
        cmd           = '0;
        cmd.st        = ST_OK;
        state_next    = state_reg;
        pop_next      = pop_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op) inside
                        OP_ENQ:
                        begin
                            cmd.push_in  = !stat.in_full;
                            cmd.load_out = 1'b1;
                            cmd.st       = stat.in_full ? ST_OVERFLOW : ST_OK;
                        end
                        OP_DEQ, OP_FRONT:
                        begin
                            pop_next = (op == OP_DEQ);
                            if (!stat.out_empty)
                            begin
                                cmd.top_rd = 1'b1;
                                state_next = S_RD_WAIT;
                            end
                            else if (!stat.in_empty)
                            begin
                                state_next = S_XFER_RD;
                            end
                            else
                            begin
                                cmd.load_out = 1'b1;
                                cmd.st       = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            cmd.load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_XFER_RD:
            begin
                cmd.xfer_rd = 1'b1;
                state_next  = S_XFER_WR;
            end
            S_XFER_WR:
            begin
                cmd.xfer_wr = 1'b1;
                state_next  = stat.in_empty ? S_TOP_RD : S_XFER_RD;
            end
            S_TOP_RD:
            begin
                cmd.top_rd = 1'b1;
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                cmd.load_out = 1'b1;
                cmd.from_ram = 1'b1;
                cmd.pop      = pop_reg;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pop_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pop_reg      <= pop_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // Checks
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !m_tvalid_reg)
        else $error("result pending while a request is in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before it was taken");

    a_refill_ends_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XFER_WR && stat.in_empty) |=> (state_reg == S_TOP_RD))
        else $error("refill did not end in a top read");

endmodule

>>> rtl/queue_from_two_stacks.sv
// ============================================================================
// queue_from_two_stacks
// First-in first-out queue built from two stacks held in block memories.
// Enqueue and the empty query load the result register directly, with no
// memory read, and can follow back to back while results are taken. Dequeue
// and front read the output stack top (one memory read) when it holds
// entries; when it is empty, the entries of the input stack are first moved
// over, each moved entry costing one read and one write. Each word moves once.
// Reset clears both fill counters at once; the stack memories are not cleared.
// ============================================================================
module queue_from_two_stacks #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic [1:0]  s_tuser,    // [1:0] func
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] result_value
    output logic [2:0]  m_tuser     // [1:0] status, [2] is_empty
);

    import qfts_pkg::*;

    qfts_cmd_t  cmd;
    qfts_stat_t stat;
    status_t    status;
    logic       is_empty;

    // Sequence requests
    qfts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Stacks and result register
    qfts_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (s_tdata),
        .stat         (stat),
        .result_value (m_tdata),
        .status       (status),
        .is_empty     (is_empty)
    );

    assign m_tuser = {is_empty, status};

endmodule
